// ===== hw/rtl/cfir_pkg.sv =====
// Shared constants and types for the complex FIR block.
package cfir_pkg;

    localparam int TAP_REGS   = 8;    // tap registers on the config port
    localparam int CFG_IDX_W  = 3;    // config index width
    localparam int TAP_W      = 32;   // packed tap: real [31:16], imag [15:0]
    localparam int COEF_W     = 16;   // one tap half, signed Q1.15
    localparam int COEF_FRAC  = 15;   // fraction bits dropped from the sum

    typedef logic [TAP_W-1:0] t_tap;

    // Reset taps: real 0.05 0.10 0.20 0.30 0.30 0.20 0.10 0.05,
    // imag 0.05 0.10 0.20 0.30 -0.30 -0.20 -0.10 -0.05 (Q1.15, rounded to nearest).
    localparam t_tap TAP_RESET [TAP_REGS] = '{
        32'd107349606, 32'd214764749, 32'd429529498, 32'd644228710,
        32'd644274586, 32'd429581926, 32'd214823731, 32'd107411866
    };

endpackage

// ===== hw/rtl/complex_fir_8tap_iq_core.sv =====
// Complex FIR core: direct-form TAPS-tap complex filter on an I/Q word stream.
// Each input word carries one complex sample (I, Q) and a block_start flag in
// tuser; block_start clears the sample history before the sample enters, so a
// block always starts from zero history. Each input word gives exactly one
// output word y[n] = sum h[k]*x[n-k] with the full complex multiply. Taps are
// Q1.15 (real in bits 31:16, imaginary in 15:0 of each tap register); the sum
// is shifted right by 15 with floor and saturated to SAMPLE_WIDTH bits. The
// datapath is a five-stage pipeline (sample window, 4*TAPS products, per-tap
// complex combine, tap sum, floor/saturate into the output register); the
// window register loads at the edge that takes the input word, and its result
// passes the product, combine, sum and output registers in turn. One word per
// clock is sustained while m_axis_tready stays high; the rate is set by the
// single product array, one set of multipliers per tap. Each stage has its own
// ready term, so bubbles are squeezed out and input words keep flowing while a
// result waits on m_axis_tready until the pipeline is full. The user must write
// taps through the config port (always ready) only while the stream is idle;
// the block does not enforce this. Indexes at or above TAPS are ignored.
module complex_fir_8tap_iq_core #(
    parameter int TAPS         = 8,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: sample_i [SW-1:0], sample_q [2SW-1:SW], zero pad to bytes
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    // tuser: block_start [0]
    input  logic                                   s_axis_tuser,
    // output stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // tdata: out_i [SW-1:0], out_q [2SW-1:SW], zero pad to bytes
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
    // config write channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [cfir_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [cfir_pkg::TAP_W-1:0]             i_cfg_data
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int DW   = ((2*SW+7)/8)*8;
    localparam int PW   = SW + cfir_pkg::COEF_W;          // one product
    localparam int TW   = PW + 1;                         // per-tap combine
    localparam int AW   = TW + $clog2(TAPS);              // tap sum
    localparam int SHW  = AW - cfir_pkg::COEF_FRAC;       // after floor shift
    localparam int TIW  = $clog2(TAPS);

    // ---------------- config: tap registers ----------------
    cfir_pkg::t_tap r_tap [TAPS];
    logic           cfg_hit;

    assign o_cfg_ready = 1'b1;
    assign cfg_hit = i_cfg_valid &&
        ((cfir_pkg::CFG_IDX_W+1)'(i_cfg_index) < (cfir_pkg::CFG_IDX_W+1)'(TAPS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TAPS; k++) r_tap[k] <= cfir_pkg::TAP_RESET[k];
        end else if (cfg_hit) begin
            r_tap[i_cfg_index[TIW-1:0]] <= i_cfg_data;
        end
    end

    // ---------------- handshake: per-stage advance ----------------
    logic [5:1] r_vld;
    logic [5:1] en;
    logic       s_acc;

    assign en[5] = !r_vld[5] || m_axis_tready;
    assign en[4] = !r_vld[4] || en[5];
    assign en[3] = !r_vld[3] || en[4];
    assign en[2] = !r_vld[2] || en[3];
    assign en[1] = !r_vld[1] || en[2];

    assign s_axis_tready = en[1];
    assign s_acc         = s_axis_tvalid && en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) r_vld[1] <= s_axis_tvalid;
            if (en[2]) r_vld[2] <= r_vld[1];
            if (en[3]) r_vld[3] <= r_vld[2];
            if (en[4]) r_vld[4] <= r_vld[3];
            if (en[5]) r_vld[5] <= r_vld[4];
        end
    end

    // ---------------- stage 1: sample window ----------------
    // Entry 0 is the newest sample; entries 0..TAPS-2 double as the history.
    logic signed [SW-1:0] r_win_i [TAPS];
    logic signed [SW-1:0] r_win_q [TAPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TAPS; k++) begin
                r_win_i[k] <= '0;
                r_win_q[k] <= '0;
            end
        end else if (s_acc) begin
            r_win_i[0] <= s_axis_tdata[SW-1:0];
            r_win_q[0] <= s_axis_tdata[2*SW-1:SW];
            for (int k = 1; k < TAPS; k++) begin
                r_win_i[k] <= s_axis_tuser ? '0 : r_win_i[k-1];
                r_win_q[k] <= s_axis_tuser ? '0 : r_win_q[k-1];
            end
        end
    end

    // ---------------- stage 2: products ----------------
    logic signed [PW-1:0] r_p_rr [TAPS];   // hr * xi
    logic signed [PW-1:0] r_p_hq [TAPS];   // hh * xq
    logic signed [PW-1:0] r_p_hi [TAPS];   // hh * xi
    logic signed [PW-1:0] r_p_rq [TAPS];   // hr * xq
    logic signed [cfir_pkg::COEF_W-1:0] hr [TAPS];
    logic signed [cfir_pkg::COEF_W-1:0] hh [TAPS];

    always_comb begin
        for (int k = 0; k < TAPS; k++) begin
            hr[k] = r_tap[k][2*cfir_pkg::COEF_W-1:cfir_pkg::COEF_W];
            hh[k] = r_tap[k][cfir_pkg::COEF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            for (int k = 0; k < TAPS; k++) begin
                r_p_rr[k] <= PW'(hr[k] * r_win_i[k]);
                r_p_hq[k] <= PW'(hh[k] * r_win_q[k]);
                r_p_hi[k] <= PW'(hh[k] * r_win_i[k]);
                r_p_rq[k] <= PW'(hr[k] * r_win_q[k]);
            end
        end
    end

    // ---------------- stage 3: per-tap complex combine ----------------
    logic signed [TW-1:0] r_t_i [TAPS];
    logic signed [TW-1:0] r_t_q [TAPS];

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            for (int k = 0; k < TAPS; k++) begin
                r_t_i[k] <= TW'(r_p_rr[k]) - TW'(r_p_hq[k]);
                r_t_q[k] <= TW'(r_p_hi[k]) + TW'(r_p_rq[k]);
            end
        end
    end

    // ---------------- stage 4: tap sum ----------------
    logic signed [AW-1:0] n_acc_i, n_acc_q;
    logic signed [AW-1:0] r_acc_i, r_acc_q;

    always_comb begin
        n_acc_i = '0;
        n_acc_q = '0;
        for (int k = 0; k < TAPS; k++) begin
            n_acc_i = n_acc_i + AW'(r_t_i[k]);
            n_acc_q = n_acc_q + AW'(r_t_q[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_acc_i <= n_acc_i;
            r_acc_q <= n_acc_q;
        end
    end

    // ---------------- stage 5: floor shift, saturate ----------------
    // Dropping the low fraction bits of a two's complement sum is a floor.
    function automatic logic [SW-1:0] sat_out(input logic [SHW-1:0] v);
        logic top_ones;
        logic top_zeros;
        top_ones  = &v[SHW-1:SW-1];
        top_zeros = ~|v[SHW-1:SW-1];
        if (top_ones || top_zeros) begin
            sat_out = v[SW-1:0];
        end else if (v[SHW-1]) begin
            sat_out = {1'b1, {(SW-1){1'b0}}};
        end else begin
            sat_out = {1'b0, {(SW-1){1'b1}}};
        end
    endfunction

    logic [SW-1:0] r_out_i, r_out_q;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_out_i <= sat_out(r_acc_i[AW-1:cfir_pkg::COEF_FRAC]);
            r_out_q <= sat_out(r_acc_q[AW-1:cfir_pkg::COEF_FRAC]);
        end
    end

    assign m_axis_tvalid = r_vld[5];
    assign m_axis_tdata  = DW'({r_out_q, r_out_i});

    // ---------------- assertions ----------------
    // Input is only held off when every stage holds a word.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (&r_vld))
        else $error("input stalled with a bubble in the pipeline");

    // A block start leaves no old history in the window.
    a_block_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && s_axis_tuser) |=> (r_win_i[TAPS-1] == '0) && (r_win_q[TAPS-1] == '0))
        else $error("history not cleared on block start");

    // A stalled output keeps the word behind it in stage 4.
    a_stage4_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[4] && r_vld[5] && !m_axis_tready) |=> (r_vld[4] && $stable(r_acc_i)))
        else $error("stage 4 word lost under output stall");

    // An out-of-range index never changes the taps; the check watches tap 0.
    a_cfg_ignore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && !cfg_hit) |=> $stable(r_tap[0]))
        else $error("out-of-range config write touched a tap");

endmodule

// ===== tb/sv/complex_fir_8tap_iq_core_tb.sv =====
// Self-checking testbench for the complex 8-tap I/Q FIR core.
module complex_fir_8tap_iq_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTAP    = 8;                 // taps in the filter under test
    localparam int SW      = 16;                // sample width
    localparam longint SAT_HI = (64'sd1 <<< (SW - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;
    localparam int HOLD_CYCLES = 64;            // long receiver hold-off
    localparam int DRAIN_LIMIT = 40000;         // bound on the final drain

    // One input word: sample_i in [15:0], sample_q in [31:16], block_start in tuser.
    typedef struct packed {
        logic               start;
        logic signed [15:0] q;
        logic signed [15:0] i;
    } t_iq_word;

    // One output word: out_i in [15:0], out_q in [31:16].
    typedef struct packed {
        logic signed [15:0] q;
        logic signed [15:0] i;
    } t_iq_out;

    // ---------------------------------------------------------------------
    // DUT signals; every input starts at a known value.
    // ---------------------------------------------------------------------
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata  = '0;  // sample_i [15:0], sample_q [31:16]
    logic                 s_axis_tuser  = 1'b0; // block_start [0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [31:0]          m_axis_tdata;         // out_i [15:0], out_q [31:16]
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [cfir_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [cfir_pkg::TAP_W-1:0]     i_cfg_data  = '0;

    complex_fir_8tap_iq_core #(
        .TAPS         (NTAP),
        .SAMPLE_WIDTH (SW)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Filter shadow: tap registers and sample history, newest first.
    // ---------------------------------------------------------------------
    cfir_pkg::t_tap     tap_regs [cfir_pkg::TAP_REGS];
    logic signed [15:0] hist_i   [NTAP-1];
    logic signed [15:0] hist_q   [NTAP-1];

    t_iq_word pending_q [$];    // words waiting for the driver
    t_iq_out  filtered_q [$];   // predicted filter outputs, oldest first

    int n_queued   = 0;
    int n_accepted = 0;
    int n_checked  = 0;
    int n_blocks   = 0;
    int n_tap_sets = 1;         // reset taps count as the first setting
    int n_err      = 0;

    // Idle controls, changed per phase by the stimulus process.
    bit send_gaps_on   = 1'b1;
    bit sink_stalls_on = 1'b1;
    int hold_left      = 0;     // receiver hold-off, counted down by the monitor

    t_iq_word cur_word;
    int       gap_left   = 0;
    int       stall_left = 0;
    t_iq_out  want_w;

    // Floor by 15 (arithmetic shift on a signed 64-bit sum), then clamp.
    function automatic logic signed [15:0] clip_q15(longint acc);
        longint v;
        v = acc >>> cfir_pkg::COEF_FRAC;
        if (v > SAT_HI) v = SAT_HI;
        else if (v < SAT_LO) v = SAT_LO;
        return v[15:0];
    endfunction

    // Advance the shadow filter by one sample and return its output.
    function automatic t_iq_out fir_advance(t_iq_word w);
        longint  win_i [NTAP];
        longint  win_q [NTAP];
        longint  acc_i, acc_q, hr, hh;
        t_iq_out r;
        // block start: the history is cleared before the sample enters
        if (w.start) begin
            foreach (hist_i[k]) begin
                hist_i[k] = '0;
                hist_q[k] = '0;
            end
        end
        win_i[0] = $signed(w.i);
        win_q[0] = $signed(w.q);
        for (int k = 1; k < NTAP; k++) begin
            win_i[k] = hist_i[k-1];
            win_q[k] = hist_q[k-1];
        end
        acc_i = 0;
        acc_q = 0;
        for (int k = 0; k < NTAP; k++) begin
            hr = $signed(tap_regs[k][31:16]);
            hh = $signed(tap_regs[k][15:0]);
            acc_i += hr * win_i[k] - hh * win_q[k];
            acc_q += hh * win_i[k] + hr * win_q[k];
        end
        for (int k = NTAP - 2; k > 0; k--) begin
            hist_i[k] = hist_i[k-1];
            hist_q[k] = hist_q[k-1];
        end
        hist_i[0] = w.i;
        hist_q[0] = w.q;
        r.i = clip_q15(acc_i);
        r.q = clip_q15(acc_q);
        return r;
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    // Samples lean toward the rails and toward zero.
    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'($urandom_range(0, 8) - 4);
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic report_mismatch(string what, int word_no, logic [31:0] want,
                                   logic [31:0] got);
        if (n_err < 30)
            $display("[%0t] MISMATCH %s at output word %0d: want %h got %h",
                     $realtime, what, word_no, want, got);
        n_err++;
    endtask

    task automatic push_word(logic signed [15:0] si, logic signed [15:0] sq, logic st);
        t_iq_word w;
        w.i     = si;
        w.q     = sq;
        w.start = st;
        pending_q.push_back(w);
        n_queued++;
        if (st) n_blocks++;
    endtask

    // Blocks of random length with random content; a few blocks drop their
    // start flag or get a stray one mid-run.
    task automatic queue_blocks(int n_items);
        int run_left;
        logic st;
        run_left = 0;
        repeat (n_items) begin
            st = (run_left == 0);
            if (run_left == 0)
                run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2)
                                                        : $urandom_range(4, 40);
            run_left--;
            if (st && $urandom_range(0, 14) == 0) st = 1'b0;
            else if (!st && $urandom_range(0, 49) == 0) st = 1'b1;
            push_word(rand_sample(), rand_sample(), st);
        end
    endtask

    // Sender pause: everything queued is taken and every output has come back.
    task automatic wait_drain();
        while (n_accepted != n_queued || n_checked != n_accepted) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write all tap registers back to back; valid stays high across the burst.
    task automatic load_taps(input cfir_pkg::t_tap vals [cfir_pkg::TAP_REGS]);
        for (int k = 0; k < cfir_pkg::TAP_REGS; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= cfir_pkg::CFG_IDX_W'(k);
            i_cfg_data  <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            tap_regs[k] = vals[k];
        end
        i_cfg_valid <= 1'b0;
        n_tap_sets++;
        @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // Driver: offers queued words, predicts each one as it is taken.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit nxt_valid;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            nxt_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                filtered_q.push_back(fir_advance(cur_word));
                n_accepted++;
                nxt_valid = 1'b0;
            end
            // tvalid stays high from one word to the next when no gap is drawn and a word is queued
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_q.size() > 0) begin
                    cur_word = pending_q.pop_front();
                    nxt_valid = 1'b1;
                    s_axis_tdata <= {cur_word.q, cur_word.i};
                    s_axis_tuser <= cur_word.start;
                    gap_left = send_gaps_on ? pick_gap() : 0;
                end
            end
            s_axis_tvalid <= nxt_valid;
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: checks each output word against the oldest prediction and
    // drives tready with random stalls and the long hold-off.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (filtered_q.size() == 0) begin
                    report_mismatch("unpredicted word", n_checked, '0, m_axis_tdata);
                end else begin
                    want_w = filtered_q.pop_front();
                    if (m_axis_tdata[15:0] !== want_w.i)
                        report_mismatch("out_i", n_checked, 32'(want_w.i),
                                        32'(m_axis_tdata[15:0]));
                    if (m_axis_tdata[31:16] !== want_w.q)
                        report_mismatch("out_q", n_checked, 32'(want_w.q),
                                        32'(m_axis_tdata[31:16]));
                    n_checked++;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (sink_stalls_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus: directed words, then random blocks under several tap sets.
    // ---------------------------------------------------------------------
    initial begin
        cfir_pkg::t_tap tv [cfir_pkg::TAP_REGS];
        int   drain_cnt;

        tap_regs = cfir_pkg::TAP_RESET;
        foreach (hist_i[k]) begin
            hist_i[k] = '0;
            hist_q[k] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset taps, no idling. An impulse reads every tap back.
        send_gaps_on   = 1'b0;
        sink_stalls_on = 1'b0;
        push_word(16'sh7FFF, 16'sh0000, 1'b1);
        repeat (7) push_word(16'sh0000, 16'sh0000, 1'b0);
        // fresh block mid-stream: history must count as zero
        push_word(16'sh0000, 16'sh8000, 1'b1);
        repeat (3) push_word(16'sh0000, 16'sh0000, 1'b0);
        // steady full-scale input: tap gain above one drives both rails
        push_word(16'sh7FFF, 16'sh7FFF, 1'b1);
        repeat (7) push_word(16'sh7FFF, 16'sh7FFF, 1'b0);
        push_word(16'sh8000, 16'sh8000, 1'b1);
        repeat (4) push_word(16'sh8000, 16'sh8000, 1'b0);
        wait_drain();

        send_gaps_on   = 1'b1;
        sink_stalls_on = 1'b1;
        queue_blocks(150);
        wait_drain();

        // Most negative taps: -1 * -1 products push the sum far over range.
        foreach (tv[k]) tv[k] = 32'h8000_8000;
        load_taps(tv);
        queue_blocks(100);
        wait_drain();

        // Most positive taps, no idling on either side.
        send_gaps_on   = 1'b0;
        sink_stalls_on = 1'b0;
        foreach (tv[k]) tv[k] = 32'h7FFF_7FFF;
        load_taps(tv);
        queue_blocks(100);
        wait_drain();

        // All-zero taps: output is zero whatever comes in.
        send_gaps_on   = 1'b1;
        sink_stalls_on = 1'b1;
        foreach (tv[k]) tv[k] = '0;
        load_taps(tv);
        queue_blocks(50);
        wait_drain();

        // Random taps under backpressure: the receiver holds off long enough
        // for the pipeline to fill and stall the input, sender never idles.
        foreach (tv[k]) tv[k] = $urandom();
        load_taps(tv);
        send_gaps_on = 1'b0;
        hold_left    = HOLD_CYCLES;
        queue_blocks(150);
        wait_drain();
        send_gaps_on = 1'b1;

        // Single real tap at the far end: a delay of seven words at a gain just under one.
        foreach (tv[k]) tv[k] = '0;
        tv[NTAP-1] = 32'h7FFF_0000;
        load_taps(tv);
        queue_blocks(100);
        wait_drain();

        // Random taps again, with a full sender pause in the middle.
        foreach (tv[k]) tv[k] = $urandom();
        load_taps(tv);
        queue_blocks(100);
        wait_drain();
        queue_blocks(100);
        wait_drain();

        // Back to the reset taps.
        tv = cfir_pkg::TAP_RESET;
        load_taps(tv);
        queue_blocks(100);

        // Final drain, bounded; anything left over is a failure.
        drain_cnt = 0;
        while ((n_accepted != n_queued || n_checked != n_accepted) &&
               drain_cnt < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cnt++;
        end
        repeat (10) @(posedge i_clk);
        if (n_accepted != n_queued || filtered_q.size() != 0)
            report_mismatch("words still outstanding", n_checked,
                            n_queued - n_accepted, filtered_q.size());

        $display("Filtered %0d I/Q words in %0d blocks across %0d tap settings;",
                 n_checked, n_blocks, n_tap_sets);
        $display("covered rail saturation, block restarts and a %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (n_err == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("Timeout waiting for output words");
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/cfir_pkg.sv
hw/rtl/complex_fir_8tap_iq_core.sv
tb/sv/complex_fir_8tap_iq_core_tb.sv
